// ===== rtl/core/lpcmu_pkg.sv =====
// Shared types and constants of the DVD LPCM block unpacker.
// No dependencies; every other file of the block but lpcmu_ram imports this package.

package lpcmu_pkg;

  localparam int MAX_CHANNELS_DEF = 8;
  localparam int CFG_W            = 4;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic [1:0] MODE_16 = 2'd0;
  localparam logic [1:0] MODE_20 = 2'd1;
  localparam logic [1:0] MODE_24 = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;

  localparam logic REG_CHANNELS = 1'b0;
  localparam logic REG_DEPTH    = 1'b1;

  typedef struct packed {
    logic        is_block;
    logic        bank;
    logic [15:0] word;
  } job_t;

endpackage

// ===== rtl/core/lpcmu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module lpcmu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/lpcmu_front.sv =====
// Front end: configuration registers, byte intake, block buffering and job creation.
// Depends on lpcmu_pkg.

module lpcmu_front #(
  parameter int MAX_CHANNELS = lpcmu_pkg::MAX_CHANNELS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic                                  cfg_index,
  input  logic [lpcmu_pkg::CFG_W-1:0]           cfg_wdata,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [7:0]                            in_tdata,
  input  logic                                  q_full,
  output logic                                  push,
  output lpcmu_pkg::job_t                       push_job,
  output logic                                  ram_we,
  output logic [$clog2(MAX_CHANNELS*6):0]       ram_waddr,
  output logic [7:0]                            ram_wdata,
  output logic [$clog2(MAX_CHANNELS+1)-1:0]     act_ch,
  output logic [1:0]                            depth_mode
);
  import lpcmu_pkg::*;

  localparam int BUF_W = $clog2(MAX_CHANNELS * 6);
  localparam int CH_W  = $clog2(MAX_CHANNELS + 1);

  logic [CFG_W-1:0] chan_r, chan_nxt;
  logic [1:0]       mode_r, mode_nxt;
  logic [BUF_W-1:0] fill_r, fill_nxt;
  logic             bank_r, bank_nxt;
  logic [7:0]       hold_r;
  logic             hold_load;
  logic             accept;
  logic             off;
  logic [BUF_W:0]   blen;
  logic [BUF_W:0]   fill_inc;

  always_comb begin
    if (chan_r > CFG_W'(MAX_CHANNELS)) begin
      act_ch = CH_W'(MAX_CHANNELS);
    end else begin
      act_ch = CH_W'(chan_r);
    end
  end

  assign depth_mode = mode_r;
  assign in_tready  = !q_full;
  assign accept     = in_tvalid && !q_full;
  assign off        = (act_ch == '0) || (mode_r == MODE_NONE);
  assign fill_inc   = {1'b0, fill_r} + 1'b1;

  always_comb begin
    if (mode_r == MODE_20) begin
      blen = (BUF_W + 1)'(act_ch) * (BUF_W + 1)'(5);
    end else begin
      blen = (BUF_W + 1)'(act_ch) * (BUF_W + 1)'(6);
    end
  end

  assign ram_waddr = {bank_r, fill_r};
  assign ram_wdata = in_tdata;

  always_comb begin
    chan_nxt  = chan_r;
    mode_nxt  = mode_r;
    fill_nxt  = fill_r;
    bank_nxt  = bank_r;
    hold_load = 1'b0;
    push      = 1'b0;
    push_job  = '0;
    ram_we    = 1'b0;
    if (accept && !off) begin
      if (mode_r == MODE_16) begin
        if (fill_r == '0) begin
          hold_load = 1'b1;
          fill_nxt  = BUF_W'(1);
        end else begin
          push          = 1'b1;
          push_job.word = {hold_r, in_tdata};
          fill_nxt      = '0;
        end
      end else begin
        ram_we = 1'b1;
        if (fill_inc == blen) begin
          push              = 1'b1;
          push_job.is_block = 1'b1;
          push_job.bank     = bank_r;
          bank_nxt          = !bank_r;
          fill_nxt          = '0;
        end else begin
          fill_nxt = fill_inc[BUF_W-1:0];
        end
      end
    end
    if (cfg_we) begin
      fill_nxt = '0;
      case (cfg_index)
        REG_CHANNELS: chan_nxt = cfg_wdata;
        REG_DEPTH:    mode_nxt = cfg_wdata[1:0];
        default:      chan_nxt = chan_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r <= CFG_W'(2);
      mode_r <= MODE_16;
      fill_r <= '0;
      bank_r <= 1'b0;
    end else begin
      chan_r <= chan_nxt;
      mode_r <= mode_nxt;
      fill_r <= fill_nxt;
      bank_r <= bank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (hold_load) begin
      hold_r <= in_tdata;
    end
  end

endmodule

// ===== rtl/core/lpcmu_queue.sv =====
// Short job queue between the front end and the sample sequencer.
// Depends on lpcmu_pkg. The head entry stays until the back end pops it.

module lpcmu_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lpcmu_pkg::job_t push_job,
  input  logic            pop,
  output lpcmu_pkg::job_t head,
  output logic            valid,
  output logic            full
);
  import lpcmu_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign head  = slot_r[rptr_r];
  assign valid = (cnt_r != '0);
  assign full  = (cnt_r == CNT_W'(QUEUE_DEPTH));

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_job;
    end
  end

endmodule

// ===== rtl/core/lpcmu_back.sv =====
// Back end: reads buffered blocks, assembles samples and drives the output register.
// Depends on lpcmu_pkg; reads the block buffer RAM through one registered port.

module lpcmu_back #(
  parameter int MAX_CHANNELS = lpcmu_pkg::MAX_CHANNELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [$clog2(MAX_CHANNELS+1)-1:0] act_ch,
  input  logic [1:0]                        depth_mode,
  input  logic                              q_valid,
  input  lpcmu_pkg::job_t                   q_head,
  output logic                              q_pop,
  output logic                              ram_re,
  output logic [$clog2(MAX_CHANNELS*6):0]   ram_raddr,
  input  logic [7:0]                        ram_rdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [31:0]                       out_tdata,
  output logic                              out_tlast
);
  import lpcmu_pkg::*;

  localparam int BUF_W = $clog2(MAX_CHANNELS * 6);
  localparam int K_W   = $clog2(2 * MAX_CHANNELS);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_HI0  = 3'd1;
  localparam logic [2:0] ST_HI1  = 3'd2;
  localparam logic [2:0] ST_LO   = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [K_W-1:0]   k_r, k_nxt;
  logic [K_W-1:0]   k_end;
  logic [7:0]       b0_r, b1_r;
  logic             out_valid_r, out_valid_nxt;
  logic [31:0]      out_sample_r, load_sample;
  logic             out_last_r, load_last;
  logic             out_load;
  logic             slot_free;
  logic [BUF_W-1:0] idx;
  logic [BUF_W-1:0] lo_base;
  logic [BUF_W-1:0] lo_idx;
  logic [7:0]       lo_part;

  assign slot_free = !out_valid_r || out_tready;
  assign k_end     = K_W'({act_ch, 1'b0} - 1'b1);
  assign lo_base   = BUF_W'({act_ch, 2'b00});
  assign lo_idx    = (depth_mode == MODE_20) ? lo_base + BUF_W'(k_r >> 1)
                                             : lo_base + BUF_W'(k_r);
  assign ram_raddr = {q_head.bank, idx};

  always_comb begin
    if (depth_mode == MODE_20) begin
      lo_part = k_r[0] ? {ram_rdata[3:0], 4'b0000} : {ram_rdata[7:4], 4'b0000};
    end else begin
      lo_part = ram_rdata;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    k_nxt       = k_r;
    q_pop       = 1'b0;
    ram_re      = 1'b0;
    idx         = BUF_W'({k_r, 1'b0});
    out_load    = 1'b0;
    load_sample = {b0_r, b1_r, lo_part, 8'h00};
    load_last   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_head.is_block) begin
            k_nxt     = '0;
            state_nxt = ST_HI0;
          end else if (slot_free) begin
            out_load    = 1'b1;
            load_sample = {16'h0000, q_head.word};
            load_last   = 1'b1;
            q_pop       = 1'b1;
          end
        end
      end
      ST_HI0: begin
        ram_re    = 1'b1;
        state_nxt = ST_HI1;
      end
      ST_HI1: begin
        ram_re    = 1'b1;
        idx       = BUF_W'({k_r, 1'b1});
        state_nxt = ST_LO;
      end
      ST_LO: begin
        ram_re    = 1'b1;
        idx       = lo_idx;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_load  = 1'b1;
          load_last = (k_r == k_end);
          if (k_r == k_end) begin
            q_pop     = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = ST_HI0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_HI1) begin
      b0_r <= ram_rdata;
    end
    if (state_r == ST_LO) begin
      b1_r <= ram_rdata;
    end
    if (out_load) begin
      out_sample_r <= load_sample;
      out_last_r   <= load_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sample_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== rtl/core/dvd_lpcm_block_unpacker.sv =====
// DVD LPCM block unpacker, top level.
// Depends on lpcmu_pkg, lpcmu_ram, lpcmu_front, lpcmu_queue and lpcmu_back.
//
// The in_ stream carries one payload byte per transfer; the out_ stream carries
// one sample per transfer, with out_tlast marking the final sample caused by a byte.
// cfg_index 0 writes the channel count and cfg_index 1 the depth mode; any write
// drops a partially collected block or byte pair. Write only while the block is idle.
// In 16-bit mode the second byte of a pair pushes a job into the queue, and the
// back end moves its sample into the output register. In 20- and 24-bit modes
// bytes go into one of two banks of a block RAM; after the last byte of a block
// the sequencer handles each sample in turn, with three reads on the single RAM
// read port in ST_HI0, ST_HI1 and ST_LO and then assembly in ST_EMIT.
// Input bytes are taken every cycle while fewer than two jobs wait in the queue.
// A stalled receiver holds the output register; the sequencer waits, the queue
// fills, and then in_tready drops. Reset empties the queue and sets two channels
// in 16-bit mode; the buffer RAM needs no clearing.

module dvd_lpcm_block_unpacker #(
  parameter int MAX_CHANNELS = lpcmu_pkg::MAX_CHANNELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [lpcmu_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // stream_byte
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [31:0]                 out_tdata,  // sample
  output logic                        out_tlast   // last_of_block
);
  import lpcmu_pkg::*;

  localparam int BUF_W     = $clog2(MAX_CHANNELS * 6);
  localparam int CH_W      = $clog2(MAX_CHANNELS + 1);
  localparam int RAM_DEPTH = 2 << BUF_W;

  logic             job_push;
  job_t             push_job;
  job_t             q_head;
  logic             q_valid;
  logic             q_full;
  logic             q_pop;
  logic             ram_we;
  logic [BUF_W:0]   ram_waddr;
  logic [7:0]       ram_wdata;
  logic             ram_re;
  logic [BUF_W:0]   ram_raddr;
  logic [7:0]       ram_rdata;
  logic [CH_W-1:0]  act_ch;
  logic [1:0]       depth_mode;

  lpcmu_front #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .q_full     (q_full),
    .push       (job_push),
    .push_job   (push_job),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .act_ch     (act_ch),
    .depth_mode (depth_mode)
  );

  lpcmu_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head     (q_head),
    .valid    (q_valid),
    .full     (q_full)
  );

  lpcmu_ram #(
    .WIDTH(8),
    .DEPTH(RAM_DEPTH)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lpcmu_back #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .act_ch     (act_ch),
    .depth_mode (depth_mode),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

`ifndef NO_ASSERTIONS
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> !q_full)
    else $error("job pushed into a full queue");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("job popped from an empty queue");

  a_bank_split: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr[BUF_W] != ram_raddr[BUF_W]))
    else $error("front end writes the bank the sequencer is reading");
`endif

endmodule
